// ===== sv/gwcs_pkg.sv =====
// shared types, codes and constants of the weighted cosine similarity block
`default_nettype none

package gwcs_pkg;

    localparam int RED_BITS = 23;
    localparam int TAYLOR_TERMS = 13;
    localparam int EXP_HALVINGS = 5;

    localparam logic [24:0] ONE24 = 25'h100_0000;
    localparam logic [32:0] ONE32 = 33'h1_0000_0000;
    localparam logic [16:0] SCORE_ONE = 17'h1_0000;

    typedef struct packed {
        logic [31:0] first_mean;
        logic [31:0] first_std;
        logic [31:0] second_mean;
        logic [31:0] second_std;
        logic        last_bin;
    } bin_t;

    typedef struct packed {
        logic [16:0] similarity;
        logic        status;
    } result_t;

    typedef enum logic [5:0] {
        OP_NONE,
        OP_LOAD,
        OP_REDUCE,
        OP_MUL_AA,
        OP_MUL_BB,
        OP_MUL_AB,
        OP_MUL_CC,
        OP_CHECK,
        OP_G_START,
        OP_G_ROOT,
        OP_G_LOAD,
        OP_X_START,
        OP_Z_LOAD,
        OP_T_MUL,
        OP_T_REC,
        OP_T_COR,
        OP_SQ_MUL,
        OP_SQ_LOAD,
        OP_W_MUL,
        OP_W_LOAD,
        OP_P_MUL,
        OP_P_HI,
        OP_P_LO,
        OP_P_ACC,
        OP_N1,
        OP_N2,
        OP_F_CHECK,
        OP_F_ROOT2,
        OP_F_DEN_MUL,
        OP_F_DEN,
        OP_F_DIV,
        OP_F_LOAD,
        OP_EMIT
    } op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_MUL_AB,
        ST_MUL_CC,
        ST_CHECK,
        ST_G_START,
        ST_G_DIV,
        ST_G_SQRT,
        ST_X_START,
        ST_X_DIV,
        ST_T_MUL,
        ST_T_REC,
        ST_T_COR,
        ST_SQ_MUL,
        ST_SQ_LOAD,
        ST_W_MUL,
        ST_W_LOAD,
        ST_P_MUL,
        ST_P_HI,
        ST_P_LO,
        ST_P_ACC,
        ST_N1,
        ST_N2,
        ST_F_CHECK,
        ST_F_SQ1,
        ST_F_SQ2,
        ST_F_DEN,
        ST_F_DIV,
        ST_F_DIVW,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] n;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic s_zero;
        logic exp_zero;
        logic g_one;
        logic last;
        logic norm_zero;
        logic score_one;
        logic out_free;
    } stat_t;

    // floor(2^32 / n) for the taylor term divisors
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        case (n)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            4'd13:   r = 33'd330382099;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/gwcs_div.sv =====
// iterative restoring divider, floor(num * 2^steps / den), one bit per cycle
`default_nettype none

module gwcs_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [5:0]  steps,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic             done,
    output logic [63:0]      quot
);

    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [63:0] quot_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic [64:0] diff;
    logic        ge;

    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        ge      = shifted >= {1'b0, den_reg};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[63:0] : shifted[63:0];
            quot_reg <= {quot_reg[62:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== sv/gwcs_sqrt.sv =====
// iterative integer square root of a 64-bit value, one result bit per cycle
`default_nettype none

module gwcs_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        fits;

    always_comb
    begin
        trial = r_reg + bit_reg;
        fits  = v_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= value;
            r_reg   <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire

// ===== sv/gwcs_dp.sv =====
// datapath: shared multiplier, divider and root units, accumulators, output register
`default_nettype none

module gwcs_dp import gwcs_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire bin_t        bin_data,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output logic             res_valid,
    input  wire logic        res_stall,
    output result_t          res_data
);

    logic [31:0] eps_reg;
    bin_t        bin_reg;
    logic [22:0] a_reg;
    logic [22:0] b_reg;
    logic [22:0] c_reg;
    logic [65:0] prod_reg;
    logic [47:0] s_reg;
    logic [47:0] num_reg;
    logic [45:0] nx_reg;
    logic [24:0] g_reg;
    logic [24:0] w_reg;
    logic [31:0] z_reg;
    logic [31:0] t_reg;
    logic [32:0] term_reg;
    logic [32:0] esum_reg;
    logic [63:0] p_reg;
    logic [63:0] hi_reg;
    logic [63:0] ws_reg;
    logic [63:0] n1_reg;
    logic [63:0] n2_reg;
    logic [63:0] den_reg;
    logic [31:0] r1_reg;
    result_t     score_reg;
    result_t     out_reg;
    logic        out_valid_reg;

    logic [32:0] su;
    logic [32:0] sv;
    logic [31:0] dd;
    logic [32:0] big;
    logic [3:0]  red_k;
    logic [32:0] su_red;
    logic [32:0] sv_red;
    logic [32:0] dd_red;

    logic        mul_en;
    logic [32:0] mul_a;
    logic [32:0] mul_b;

    logic [31:0] q_est;
    logic [35:0] qn;
    logic [31:0] t_rem;
    logic [32:0] t_new;
    logic [63:0] p_term;
    logic [52:0] s48;

    logic        div_start;
    logic [5:0]  div_steps;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic        div_done;
    logic [63:0] div_quot;
    logic        sqrt_start;
    logic [63:0] sqrt_value;
    logic        sqrt_done;
    logic [31:0] sqrt_root;

    // range reduction: shift all three so the largest fits in 23 bits
    always_comb
    begin
        su  = {1'b0, bin_reg.first_std} + {1'b0, eps_reg};
        sv  = {1'b0, bin_reg.second_std} + {1'b0, eps_reg};
        dd  = (bin_reg.first_mean >= bin_reg.second_mean) ?
              (bin_reg.first_mean - bin_reg.second_mean) :
              (bin_reg.second_mean - bin_reg.first_mean);
        big = (su >= sv) ? su : sv;
        if ({1'b0, dd} > big)
        begin
            big = {1'b0, dd};
        end
        red_k = '0;
        for (int j = 0; j < 10; j++)
        begin
            if ((big >> (RED_BITS + j)) != 33'd0)
            begin
                red_k = 4'(j + 1);
            end
        end
        su_red = su >> red_k;
        sv_red = sv >> red_k;
        dd_red = {1'b0, dd} >> red_k;
    end

    // taylor term divide by n via reciprocal and one correction
    always_comb
    begin
        q_est = prod_reg[63:32];
        qn    = {4'b0, q_est} * {32'b0, cmd.n};
        t_rem = t_reg - qn[31:0];
        t_new = {1'b0, q_est} + {32'b0, (t_rem >= {28'b0, cmd.n})};
    end

    always_comb
    begin
        p_term = (w_reg >= ONE24) ? p_reg : (hi_reg + {24'b0, prod_reg[63:24]});
        s48    = ({5'b0, s_reg} << 5) + ({5'b0, s_reg} << 4);
    end

    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_MUL_AA:
            begin
                mul_a = {10'b0, a_reg};
                mul_b = {10'b0, a_reg};
            end
            OP_MUL_BB:
            begin
                mul_a = {10'b0, b_reg};
                mul_b = {10'b0, b_reg};
            end
            OP_MUL_AB:
            begin
                mul_a = {10'b0, a_reg};
                mul_b = {10'b0, b_reg};
            end
            OP_MUL_CC:
            begin
                mul_a = {10'b0, c_reg};
                mul_b = {10'b0, c_reg};
            end
            OP_T_MUL:
            begin
                mul_a = term_reg;
                mul_b = {1'b0, z_reg};
            end
            OP_T_REC:
            begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = recip(cmd.n);
            end
            OP_SQ_MUL:
            begin
                mul_a = esum_reg;
                mul_b = esum_reg;
            end
            OP_W_MUL:
            begin
                mul_a = {8'b0, g_reg};
                mul_b = {8'b0, esum_reg[32:8]};
            end
            OP_P_MUL:
            begin
                mul_a = {1'b0, bin_reg.first_mean};
                mul_b = {1'b0, bin_reg.second_mean};
            end
            OP_P_HI:
            begin
                mul_a = {1'b0, prod_reg[63:32]};
                mul_b = {9'b0, w_reg[23:0]};
            end
            OP_P_LO:
            begin
                mul_a = {1'b0, p_reg[31:0]};
                mul_b = {9'b0, w_reg[23:0]};
            end
            OP_P_ACC:
            begin
                mul_a = {1'b0, bin_reg.first_mean};
                mul_b = {1'b0, bin_reg.first_mean};
            end
            OP_N1:
            begin
                mul_a = {1'b0, bin_reg.second_mean};
                mul_b = {1'b0, bin_reg.second_mean};
            end
            OP_F_DEN_MUL:
            begin
                mul_a = {1'b0, r1_reg};
                mul_b = {1'b0, sqrt_root};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        div_start  = 1'b0;
        div_steps  = 6'd32;
        div_num    = {16'b0, num_reg};
        div_den    = {16'b0, s_reg};
        sqrt_start = 1'b0;
        sqrt_value = {16'b0, div_quot[31:0], 16'b0};
        case (cmd.op)
            OP_G_START:
            begin
                div_start = !stat.g_one;
            end
            OP_X_START:
            begin
                // x = nx / (2s) in q.32 taken as nx * 2^37 / (64 s)
                div_start = 1'b1;
                div_steps = 6'd37;
                div_num   = {18'b0, nx_reg};
                div_den   = {10'b0, s_reg, 6'b0};
            end
            OP_F_DIV:
            begin
                div_start = !stat.score_one;
                div_steps = 6'd16;
                div_num   = ws_reg;
                div_den   = den_reg;
            end
            OP_G_ROOT:
            begin
                sqrt_start = 1'b1;
            end
            OP_F_CHECK:
            begin
                sqrt_start = !stat.norm_zero;
                sqrt_value = n1_reg;
            end
            OP_F_ROOT2:
            begin
                sqrt_start = 1'b1;
                sqrt_value = n2_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    gwcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .steps (div_steps),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    gwcs_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sqrt_value),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    always_comb
    begin
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
        stat.s_zero    = (s_reg == 48'd0);
        stat.exp_zero  = ({7'b0, prod_reg[45:0]} >= s48);
        stat.g_one     = (num_reg >= s_reg);
        stat.last      = bin_reg.last_bin;
        stat.norm_zero = (n1_reg == 64'd0) || (n2_reg == 64'd0);
        stat.score_one = (ws_reg >= den_reg);
        stat.out_free  = !out_valid_reg || !res_stall;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.op)
            OP_LOAD:
            begin
                bin_reg <= bin_data;
            end
            OP_REDUCE:
            begin
                a_reg <= su_red[22:0];
                b_reg <= sv_red[22:0];
                c_reg <= dd_red[22:0];
            end
            OP_MUL_BB:
            begin
                s_reg <= prod_reg[47:0];
            end
            OP_MUL_AB:
            begin
                s_reg <= s_reg + prod_reg[47:0];
            end
            OP_MUL_CC:
            begin
                num_reg <= {prod_reg[46:0], 1'b0};
            end
            OP_CHECK:
            begin
                nx_reg <= prod_reg[45:0];
                w_reg  <= (stat.s_zero && (c_reg == 23'd0)) ? ONE24 : 25'd0;
            end
            OP_G_START:
            begin
                if (stat.g_one)
                begin
                    g_reg <= ONE24;
                end
            end
            OP_G_LOAD:
            begin
                g_reg <= sqrt_root[24:0];
            end
            OP_Z_LOAD:
            begin
                z_reg    <= div_quot[36:5];
                term_reg <= ONE32;
                esum_reg <= ONE32;
            end
            OP_T_REC:
            begin
                t_reg <= prod_reg[63:32];
            end
            OP_T_COR:
            begin
                term_reg <= t_new;
                esum_reg <= cmd.n[0] ? (esum_reg - t_new) : (esum_reg + t_new);
            end
            OP_SQ_LOAD:
            begin
                if (esum_reg < ONE32)
                begin
                    esum_reg <= {1'b0, prod_reg[63:32]};
                end
            end
            OP_W_LOAD:
            begin
                w_reg <= prod_reg[48:24];
            end
            OP_P_HI:
            begin
                p_reg <= prod_reg[63:0];
            end
            OP_P_LO:
            begin
                hi_reg <= {prod_reg[55:0], 8'b0};
            end
            OP_F_CHECK:
            begin
                if (stat.norm_zero)
                begin
                    score_reg <= '{similarity: 17'd0, status: 1'b1};
                end
            end
            OP_F_ROOT2:
            begin
                r1_reg <= sqrt_root;
            end
            OP_F_DEN:
            begin
                den_reg <= prod_reg[63:0];
            end
            OP_F_DIV:
            begin
                if (stat.score_one)
                begin
                    score_reg <= '{similarity: SCORE_ONE, status: 1'b0};
                end
            end
            OP_F_LOAD:
            begin
                score_reg <= '{similarity: {1'b0, div_quot[15:0]}, status: 1'b0};
            end
            OP_EMIT:
            begin
                out_reg <= score_reg;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg       <= 32'd1;
            ws_reg        <= '0;
            n1_reg        <= '0;
            n2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
            case (cmd.op)
                OP_P_ACC: ws_reg <= sat_add(ws_reg, p_term);
                OP_N1:    n1_reg <= sat_add(n1_reg, prod_reg[63:0]);
                OP_N2:    n2_reg <= sat_add(n2_reg, prod_reg[63:0]);
                OP_EMIT:
                begin
                    ws_reg <= '0;
                    n1_reg <= '0;
                    n2_reg <= '0;
                end
                default:  ws_reg <= ws_reg;
            endcase
            if (cmd.op == OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = out_valid_reg;
    assign res_data  = out_reg;

    a_g_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_G_LOAD |=> g_reg <= ONE24)
        else $error("weight root above one");

    a_div_fix: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_T_COR |-> t_rem < {27'b0, cmd.n, 1'b0})
        else $error("reciprocal estimate off by more than one");

    a_esum_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SQ_LOAD |=> esum_reg <= ONE32)
        else $error("exponential above one");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_EMIT |=> (ws_reg == 64'd0) && (n1_reg == 64'd0) && (n2_reg == 64'd0))
        else $error("accumulators not cleared after result");

endmodule

`default_nettype wire

// ===== sv/gwcs_ctrl.sv =====
// controller state machine sequencing the datapath for each bin
`default_nettype none

module gwcs_ctrl import gwcs_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  bin_valid,
    output logic       bin_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t     state_reg;
    state_t     state_next;
    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.n      = cnt_reg;
        bin_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                bin_stall = 1'b0;
                if (bin_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.op     = OP_REDUCE;
                state_next = ST_MUL_AA;
            end
            ST_MUL_AA:
            begin
                cmd.op     = OP_MUL_AA;
                state_next = ST_MUL_BB;
            end
            ST_MUL_BB:
            begin
                cmd.op     = OP_MUL_BB;
                state_next = ST_MUL_AB;
            end
            ST_MUL_AB:
            begin
                cmd.op     = OP_MUL_AB;
                state_next = ST_MUL_CC;
            end
            ST_MUL_CC:
            begin
                cmd.op     = OP_MUL_CC;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                // degenerate stds or a vanishing exponential skip straight to accumulate
                cmd.op     = OP_CHECK;
                state_next = (stat.s_zero || stat.exp_zero) ? ST_P_MUL : ST_G_START;
            end
            ST_G_START:
            begin
                cmd.op     = OP_G_START;
                state_next = stat.g_one ? ST_X_START : ST_G_DIV;
            end
            ST_G_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_G_ROOT;
                    state_next = ST_G_SQRT;
                end
            end
            ST_G_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_G_LOAD;
                    state_next = ST_X_START;
                end
            end
            ST_X_START:
            begin
                cmd.op     = OP_X_START;
                state_next = ST_X_DIV;
            end
            ST_X_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_Z_LOAD;
                    cnt_next   = 4'd1;
                    state_next = ST_T_MUL;
                end
            end
            ST_T_MUL:
            begin
                cmd.op     = OP_T_MUL;
                state_next = ST_T_REC;
            end
            ST_T_REC:
            begin
                cmd.op     = OP_T_REC;
                state_next = ST_T_COR;
            end
            ST_T_COR:
            begin
                cmd.op = OP_T_COR;
                if (cnt_reg == 4'(TAYLOR_TERMS))
                begin
                    cnt_next   = 4'd1;
                    state_next = ST_SQ_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_T_MUL;
                end
            end
            ST_SQ_MUL:
            begin
                cmd.op     = OP_SQ_MUL;
                state_next = ST_SQ_LOAD;
            end
            ST_SQ_LOAD:
            begin
                cmd.op = OP_SQ_LOAD;
                if (cnt_reg == 4'(EXP_HALVINGS))
                begin
                    state_next = ST_W_MUL;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_W_MUL:
            begin
                cmd.op     = OP_W_MUL;
                state_next = ST_W_LOAD;
            end
            ST_W_LOAD:
            begin
                cmd.op     = OP_W_LOAD;
                state_next = ST_P_MUL;
            end
            ST_P_MUL:
            begin
                cmd.op     = OP_P_MUL;
                state_next = ST_P_HI;
            end
            ST_P_HI:
            begin
                cmd.op     = OP_P_HI;
                state_next = ST_P_LO;
            end
            ST_P_LO:
            begin
                cmd.op     = OP_P_LO;
                state_next = ST_P_ACC;
            end
            ST_P_ACC:
            begin
                cmd.op     = OP_P_ACC;
                state_next = ST_N1;
            end
            ST_N1:
            begin
                cmd.op     = OP_N1;
                state_next = ST_N2;
            end
            ST_N2:
            begin
                cmd.op     = OP_N2;
                state_next = stat.last ? ST_F_CHECK : ST_IDLE;
            end
            ST_F_CHECK:
            begin
                cmd.op     = OP_F_CHECK;
                state_next = stat.norm_zero ? ST_EMIT : ST_F_SQ1;
            end
            ST_F_SQ1:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_F_ROOT2;
                    state_next = ST_F_SQ2;
                end
            end
            ST_F_SQ2:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.op     = OP_F_DEN_MUL;
                    state_next = ST_F_DEN;
                end
            end
            ST_F_DEN:
            begin
                cmd.op     = OP_F_DEN;
                state_next = ST_F_DIV;
            end
            ST_F_DIV:
            begin
                cmd.op     = OP_F_DIV;
                state_next = stat.score_one ? ST_EMIT : ST_F_DIVW;
            end
            ST_F_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.op     = OP_F_LOAD;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/gaussian_weighted_cosine_similarity.sv =====
// top level of the gaussian weighted cosine similarity block
// one bin at a time: a bin goes straight to accumulate when its weight is trivially zero
// or the stds vanish, skips the weight divide and root when both reduced stds match, and
// otherwise runs a 32-bit divide, a 32-bit root, a 37-bit divide and 13 taylor terms on
// the shared multiplier; a last bin adds two 32-bit roots, a 16-bit divide and result stall
// rst_n is asynchronous: control state and accumulators clear, std_epsilon returns to 1
`default_nettype none

module gaussian_weighted_cosine_similarity import gwcs_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        bin_valid,
    output logic             bin_stall,
    input  wire bin_t        bin_data,
    output logic             res_valid,
    input  wire logic        res_stall,
    output result_t          res_data
);

    cmd_t  cmd;
    stat_t stat;

    gwcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .bin_valid (bin_valid),
        .bin_stall (bin_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    gwcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bin_data  (bin_data),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

`default_nettype wire
